// ----- rtl/core/two_point_voltage_calibration_macros.svh -----
// Assertion macros used by the checker of the calibration block.
// No dependencies; include by bare file name.
`ifndef TWO_POINT_VOLTAGE_CALIBRATION_MACROS_SVH
`define TWO_POINT_VOLTAGE_CALIBRATION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TPVC_ASSERT_IMM(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TPVC_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tpvc_pkg.sv -----
// Package of the two-point voltage calibration block: item and limit types,
// micro-operation codes and the sequencer's control store. No dependencies.
package tpvc_pkg;

  // Register indexes of the configuration port
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_MAX   = 2'd0,
    REG_GAIN_MIN   = 2'd1,
    REG_OFFSET_MAX = 2'd2,
    REG_OFFSET_MIN = 2'd3
  } tpvc_reg_e;

  localparam logic signed [15:0] GAIN_MAX_RST   = 16'sd8192;
  localparam logic signed [15:0] GAIN_MIN_RST   = 16'sd2048;
  localparam logic signed [15:0] OFFSET_MAX_RST = 16'sd1000;
  localparam logic signed [15:0] OFFSET_MIN_RST = -16'sd1000;

  typedef struct packed {
    logic signed [15:0] gain_max;
    logic signed [15:0] gain_min;
    logic signed [15:0] offset_max;
    logic signed [15:0] offset_min;
  } tpvc_limits_t;

  typedef struct packed {
    logic signed [15:0] reference_volts;
    logic signed [15:0] port_raw;
    logic signed [15:0] module_raw;
    logic signed [15:0] port_gain_in;
    logic signed [15:0] port_offset_in;
    logic signed [15:0] module_gain_in;
    logic signed [15:0] module_offset_in;
  } tpvc_item_t;

  typedef struct packed {
    logic               applied;
    logic signed [15:0] port_gain_out;
    logic signed [15:0] port_offset_out;
    logic signed [15:0] module_gain_out;
    logic signed [15:0] module_offset_out;
  } tpvc_result_t;

  // Micro-operations of the datapath
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_MUL_RAW,
    OP_ZERO,
    OP_MUL_GAIN,
    OP_GAIN,
    OP_OFFSET,
    OP_EMIT_APPLY,
    OP_EMIT_STORE
  } tpvc_op_e;

  // Step gating: the step waits until its handshake side is ready
  typedef enum logic [1:0] {
    GATE_NONE,
    GATE_IN,
    GATE_OUT
  } tpvc_gate_e;

  // Sequencing of the step counter
  typedef enum logic [1:0] {
    COND_NEXT,
    COND_GOTO,
    COND_NOT_HELD,
    COND_DIV_MORE
  } tpvc_cond_e;

  localparam int unsigned STEP_W = 5;

  localparam logic [STEP_W-1:0] STEP_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] STEP_DIV_P    = 5'd2;
  localparam logic [STEP_W-1:0] STEP_DIV_M    = 5'd10;
  localparam logic [STEP_W-1:0] STEP_STORE    = 5'd18;

  typedef struct packed {
    tpvc_op_e          op;
    logic              ch;
    tpvc_gate_e        gate;
    tpvc_cond_e        cond;
    logic [STEP_W-1:0] target;
  } tpvc_uword_t;

  // Datapath control for the current step
  typedef struct packed {
    tpvc_op_e op;
    logic     ch;
    logic     fire;
  } tpvc_ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic held;
    logic div_last;
    logic out_free;
  } tpvc_stat_t;

  function automatic tpvc_uword_t tpvc_uw(input tpvc_op_e op, input logic ch,
                                          input tpvc_gate_e gate,
                                          input tpvc_cond_e cond,
                                          input logic [STEP_W-1:0] target);
    tpvc_uword_t w;
    w.op     = op;
    w.ch     = ch;
    w.gate   = gate;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Control store: channel 0 is the port, channel 1 the module
  function automatic tpvc_uword_t tpvc_rom(input logic [STEP_W-1:0] pc);
    tpvc_uword_t w;
    unique case (pc)
      5'd0:  w = tpvc_uw(OP_LATCH,      1'b0, GATE_IN,   COND_NEXT,     STEP_IDLE);
      5'd1:  w = tpvc_uw(OP_DIV_LOAD,   1'b0, GATE_NONE, COND_NOT_HELD, STEP_STORE);
      5'd2:  w = tpvc_uw(OP_DIV_STEP,   1'b0, GATE_NONE, COND_DIV_MORE, STEP_DIV_P);
      5'd3:  w = tpvc_uw(OP_DIV_DONE,   1'b0, GATE_NONE, COND_NEXT,     STEP_IDLE);
      5'd4:  w = tpvc_uw(OP_MUL_RAW,    1'b0, GATE_NONE, COND_NEXT,     STEP_IDLE);
      5'd5:  w = tpvc_uw(OP_ZERO,       1'b0, GATE_NONE, COND_NEXT,     STEP_IDLE);
      5'd6:  w = tpvc_uw(OP_MUL_GAIN,   1'b0, GATE_NONE, COND_NEXT,     STEP_IDLE);
      5'd7:  w = tpvc_uw(OP_GAIN,       1'b0, GATE_NONE, COND_NEXT,     STEP_IDLE);
      5'd8:  w = tpvc_uw(OP_OFFSET,     1'b0, GATE_NONE, COND_NEXT,     STEP_IDLE);
      5'd9:  w = tpvc_uw(OP_DIV_LOAD,   1'b1, GATE_NONE, COND_NEXT,     STEP_IDLE);
      5'd10: w = tpvc_uw(OP_DIV_STEP,   1'b1, GATE_NONE, COND_DIV_MORE, STEP_DIV_M);
      5'd11: w = tpvc_uw(OP_DIV_DONE,   1'b1, GATE_NONE, COND_NEXT,     STEP_IDLE);
      5'd12: w = tpvc_uw(OP_MUL_RAW,    1'b1, GATE_NONE, COND_NEXT,     STEP_IDLE);
      5'd13: w = tpvc_uw(OP_ZERO,       1'b1, GATE_NONE, COND_NEXT,     STEP_IDLE);
      5'd14: w = tpvc_uw(OP_MUL_GAIN,   1'b1, GATE_NONE, COND_NEXT,     STEP_IDLE);
      5'd15: w = tpvc_uw(OP_GAIN,       1'b1, GATE_NONE, COND_NEXT,     STEP_IDLE);
      5'd16: w = tpvc_uw(OP_OFFSET,     1'b1, GATE_NONE, COND_NEXT,     STEP_IDLE);
      5'd17: w = tpvc_uw(OP_EMIT_APPLY, 1'b0, GATE_OUT,  COND_GOTO,     STEP_IDLE);
      5'd18: w = tpvc_uw(OP_EMIT_STORE, 1'b0, GATE_OUT,  COND_GOTO,     STEP_IDLE);
      default: w = tpvc_uw(OP_NOP,      1'b0, GATE_NONE, COND_GOTO,     STEP_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/tpvc_if.sv -----
// Item channels of the calibration block: input points and result items.
// Standalone; no package needed.
interface tpvc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] reference_volts;
  logic signed [15:0] port_raw;
  logic signed [15:0] module_raw;
  logic signed [15:0] port_gain_in;
  logic signed [15:0] port_offset_in;
  logic signed [15:0] module_gain_in;
  logic signed [15:0] module_offset_in;

  modport source (
    output valid, reference_volts, port_raw, module_raw, port_gain_in,
           port_offset_in, module_gain_in, module_offset_in,
    input  ready
  );
  modport sink (
    input  valid, reference_volts, port_raw, module_raw, port_gain_in,
           port_offset_in, module_gain_in, module_offset_in,
    output ready
  );
endinterface

interface tpvc_out_if;
  logic               valid;
  logic               ready;
  logic               applied;
  logic signed [15:0] port_gain_out;
  logic signed [15:0] port_offset_out;
  logic signed [15:0] module_gain_out;
  logic signed [15:0] module_offset_out;

  modport source (
    output valid, applied, port_gain_out, port_offset_out, module_gain_out,
           module_offset_out,
    input  ready
  );
  modport sink (
    input  valid, applied, port_gain_out, port_offset_out, module_gain_out,
           module_offset_out,
    output ready
  );
endinterface

// ----- rtl/core/tpvc_seq.sv -----
// Microcoded sequencer: step counter over the control store in tpvc_pkg,
// with handshake gating and conditional jumps. Depends on tpvc_pkg.
module tpvc_seq import tpvc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  tpvc_stat_t stat_i,
  output logic       in_ready_o,
  output tpvc_ctrl_t ctrl_o
);

  logic [STEP_W-1:0] pc_q, pc_d;
  tpvc_uword_t       uw;
  logic              gate_ok;

  assign uw = tpvc_rom(pc_q);

  // Hold the step until its handshake side can move
  always_comb begin
    unique case (uw.gate)
      GATE_NONE: gate_ok = 1'b1;
      GATE_IN:   gate_ok = in_valid_i;
      GATE_OUT:  gate_ok = stat_i.out_free;
      default:   gate_ok = 1'b0;
    endcase
  end

  assign in_ready_o = (uw.gate == GATE_IN);

  // Advance or jump
  always_comb begin
    pc_d = pc_q;
    if (gate_ok) begin
      unique case (uw.cond)
        COND_NEXT:     pc_d = pc_q + 1'b1;
        COND_GOTO:     pc_d = uw.target;
        COND_NOT_HELD: pc_d = stat_i.held ? pc_q + 1'b1 : uw.target;
        COND_DIV_MORE: pc_d = stat_i.div_last ? pc_q + 1'b1 : uw.target;
        default:       pc_d = STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op   = uw.op;
  assign ctrl_o.ch   = uw.ch;
  assign ctrl_o.fire = gate_ok;

endmodule

// ----- rtl/core/tpvc_dp.sv -----
// Datapath of the calibration block: held point, serial restoring divider,
// shared multiplier, clamps and the output register. Depends on tpvc_pkg.
module tpvc_dp import tpvc_pkg::*; #(
  parameter int unsigned SLOPE_FRAC_BITS = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tpvc_ctrl_t   ctrl_i,
  input  tpvc_item_t   item_i,
  input  tpvc_limits_t limits_i,
  input  logic         out_ready_i,
  output tpvc_stat_t   stat_o,
  output logic         out_valid_o,
  output tpvc_result_t res_o
);

  // Quotient bits; the slope is kept modulo 2^KW, enough for bits 16+F-1..F
  localparam int unsigned NQ = 16 + SLOPE_FRAC_BITS;
  localparam int unsigned KW = NQ;
  localparam int unsigned CW = $clog2(NQ + 1);

  function automatic logic signed [15:0] clamp16(input logic signed [15:0] x,
                                                 input logic signed [15:0] hi,
                                                 input logic signed [15:0] lo);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  tpvc_item_t         item_q;
  logic               held_q;
  logic signed [15:0] first_ref_q, first_praw_q, first_mraw_q;
  logic [15:0]        rem_q, dsr_q;
  logic [NQ-1:0]      dvd_q;
  logic               neg_q;
  logic [CW-1:0]      cnt_q;
  logic [KW-1:0]      k_q, prod_q;
  logic signed [15:0] zero_q;
  logic signed [15:0] pg_q, po_q, mg_q, mo_q;
  tpvc_result_t       out_q;
  logic               out_valid_q;

  logic signed [15:0] sel_raw, sel_first, sel_gain, sel_off, opnd, hi16, off_sum;
  logic signed [16:0] dy, dx;
  logic [16:0]        dy_neg, dx_neg;
  logic [15:0]        dy_mag, dx_mag;
  logic [16:0]        r2;
  logic               r_ge;
  logic [16:0]        r_diff;
  logic [KW-1:0]      mul_b, prod_d;
  logic               fire_emit;

  // Channel selection
  assign sel_raw   = ctrl_i.ch ? item_q.module_raw       : item_q.port_raw;
  assign sel_first = ctrl_i.ch ? first_mraw_q            : first_praw_q;
  assign sel_gain  = ctrl_i.ch ? item_q.module_gain_in   : item_q.port_gain_in;
  assign sel_off   = ctrl_i.ch ? item_q.module_offset_in : item_q.port_offset_in;

  // Differences and their magnitudes; a zero raw difference divides by one
  assign dy     = {item_q.reference_volts[15], item_q.reference_volts}
                - {first_ref_q[15], first_ref_q};
  assign dx     = {sel_raw[15], sel_raw} - {sel_first[15], sel_first};
  assign dy_neg = 17'd0 - dy;
  assign dx_neg = 17'd0 - dx;
  assign dy_mag = dy[16] ? dy_neg[15:0] : dy[15:0];
  assign dx_mag = (dx == 17'sd0) ? 16'd1 : (dx[16] ? dx_neg[15:0] : dx[15:0]);

  // One restoring division step
  assign r2     = {rem_q, dvd_q[NQ-1]};
  assign r_ge   = (r2 >= {1'b0, dsr_q});
  assign r_diff = r2 - {1'b0, dsr_q};

  // Shared multiplier, low KW bits of the product
  assign opnd   = (ctrl_i.op == OP_MUL_RAW) ? sel_first : sel_gain;
  assign mul_b  = {{(KW-16){opnd[15]}}, opnd};
  assign prod_d = k_q * mul_b;
  assign hi16   = prod_q[KW-1:SLOPE_FRAC_BITS];

  assign off_sum = zero_q + sel_off;

  assign fire_emit = ctrl_i.fire
                   && ((ctrl_i.op == OP_EMIT_APPLY) || (ctrl_i.op == OP_EMIT_STORE));

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (fire_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl_i.fire) begin
        unique case (ctrl_i.op)
          OP_DIV_LOAD:   cnt_q  <= CW'(NQ);
          OP_DIV_STEP:   cnt_q  <= cnt_q - 1'b1;
          OP_EMIT_APPLY: held_q <= 1'b0;
          OP_EMIT_STORE: held_q <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire) begin
      unique case (ctrl_i.op) inside
        OP_LATCH: item_q <= item_i;
        OP_DIV_LOAD: begin
          rem_q <= '0;
          dsr_q <= dx_mag;
          dvd_q <= {dy_mag, {SLOPE_FRAC_BITS{1'b0}}};
          neg_q <= dy[16] ^ dx[16];
        end
        OP_DIV_STEP: begin
          rem_q <= r_ge ? r_diff[15:0] : r2[15:0];
          dvd_q <= {dvd_q[NQ-2:0], r_ge};
        end
        OP_DIV_DONE: k_q <= neg_q ? (KW'(0) - dvd_q) : dvd_q;
        OP_MUL_RAW, OP_MUL_GAIN: prod_q <= prod_d;
        OP_ZERO: zero_q <= first_ref_q - hi16;
        OP_GAIN: begin
          if (ctrl_i.ch) begin
            mg_q <= clamp16(hi16, limits_i.gain_max, limits_i.gain_min);
          end else begin
            pg_q <= clamp16(hi16, limits_i.gain_max, limits_i.gain_min);
          end
        end
        OP_OFFSET: begin
          if (ctrl_i.ch) begin
            mo_q <= clamp16(off_sum, limits_i.offset_max, limits_i.offset_min);
          end else begin
            po_q <= clamp16(off_sum, limits_i.offset_max, limits_i.offset_min);
          end
        end
        OP_EMIT_APPLY: begin
          out_q.applied           <= 1'b1;
          out_q.port_gain_out     <= pg_q;
          out_q.port_offset_out   <= po_q;
          out_q.module_gain_out   <= mg_q;
          out_q.module_offset_out <= mo_q;
        end
        OP_EMIT_STORE: begin
          first_ref_q             <= item_q.reference_volts;
          first_praw_q            <= item_q.port_raw;
          first_mraw_q            <= item_q.module_raw;
          out_q.applied           <= 1'b0;
          out_q.port_gain_out     <= item_q.port_gain_in;
          out_q.port_offset_out   <= item_q.port_offset_in;
          out_q.module_gain_out   <= item_q.module_gain_in;
          out_q.module_offset_out <= item_q.module_offset_in;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.held     = held_q;
  assign stat_o.div_last = (cnt_q == CW'(1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign res_o           = out_q;

endmodule

// ----- rtl/core/two_point_voltage_calibration.sv -----
// Two-point voltage calibration for the port and module channels.
//
// Channels: in_ch takes one calibration point per item (reference, two raw
// readings, present gain and offset of each channel); out_ch gives one
// result item per input item. Both move an item when valid and ready are
// high at a rising clock edge.
// The first item of a pair is held as the first point and comes back with
// applied low and its coefficients unchanged. The second item yields new
// Q12 gains and offsets with applied high; the serial divider produces one
// quotient bit per cycle for each channel's slope. A new item can be taken
// in the cycle after the previous result is loaded into the output register.
// A stalled receiver holds the result in the output register; one further
// item is taken and worked on, then waits at its last step.
// Reset clears the held point, the sequencer and the output valid, and loads
// the limit registers with their defaults. Limits are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while no
// item is in progress, which the block itself does not enforce.
module two_point_voltage_calibration import tpvc_pkg::*; #(
  parameter int unsigned SLOPE_FRAC_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tpvc_in_if.sink              in_ch,
  tpvc_out_if.source           out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);

  tpvc_limits_t limits_q;
  tpvc_item_t   item;
  tpvc_result_t res;
  tpvc_ctrl_t   ctrl;
  tpvc_stat_t   stat;
  logic         out_valid;

  // Limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.gain_max   <= GAIN_MAX_RST;
      limits_q.gain_min   <= GAIN_MIN_RST;
      limits_q.offset_max <= OFFSET_MAX_RST;
      limits_q.offset_min <= OFFSET_MIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN_MAX:   limits_q.gain_max   <= cfg_data_i;
        REG_GAIN_MIN:   limits_q.gain_min   <= cfg_data_i;
        REG_OFFSET_MAX: limits_q.offset_max <= cfg_data_i;
        REG_OFFSET_MIN: limits_q.offset_min <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Gather the input item
  assign item.reference_volts  = in_ch.reference_volts;
  assign item.port_raw         = in_ch.port_raw;
  assign item.module_raw       = in_ch.module_raw;
  assign item.port_gain_in     = in_ch.port_gain_in;
  assign item.port_offset_in   = in_ch.port_offset_in;
  assign item.module_gain_in   = in_ch.module_gain_in;
  assign item.module_offset_in = in_ch.module_offset_in;

  tpvc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .stat_i     (stat),
    .in_ready_o (in_ch.ready),
    .ctrl_o     (ctrl)
  );

  tpvc_dp #(
    .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .item_i      (item),
    .limits_i    (limits_q),
    .out_ready_i (out_ch.ready),
    .stat_o      (stat),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  // Drive the result channel
  assign out_ch.valid             = out_valid;
  assign out_ch.applied           = res.applied;
  assign out_ch.port_gain_out     = res.port_gain_out;
  assign out_ch.port_offset_out   = res.port_offset_out;
  assign out_ch.module_gain_out   = res.module_gain_out;
  assign out_ch.module_offset_out = res.module_offset_out;

endmodule

// ----- rtl/core/tpvc_checker.sv -----
// Port-level checker for the calibration block, bound to its top level.
// Depends on two_point_voltage_calibration_macros.svh.
`include "two_point_voltage_calibration_macros.svh"

module tpvc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_applied_i,
  input logic [63:0] out_data_i
);

  logic [1:0] inflight_q;
  logic       exp_applied_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Track items in flight and the expected point of the next result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q    <= '0;
      exp_applied_q <= 1'b0;
    end else begin
      inflight_q <= inflight_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        exp_applied_q <= !exp_applied_q;
      end
    end
  end

  `TPVC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(out_data_i) && $stable(out_applied_i),
                   "result dropped or changed while stalled")
  `TPVC_ASSERT_IMM(a_alternate, clk_i, rst_ni, out_valid_i,
                   out_applied_i == exp_applied_q,
                   "stored and applied results out of turn")
  `TPVC_ASSERT_IMM(a_inflight, clk_i, rst_ni, 1'b1, inflight_q <= 2'd2,
                   "more than two items in flight")
  `TPVC_ASSERT_IMM(a_full_stall, clk_i, rst_ni, inflight_q == 2'd2, !in_ready_i,
                   "item taken while block is full")

endmodule

bind two_point_voltage_calibration tpvc_checker u_tpvc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .out_applied_i (out_ch.applied),
  .out_data_i    ({out_ch.port_gain_out, out_ch.port_offset_out,
                   out_ch.module_gain_out, out_ch.module_offset_out})
);
